[src/rmq_pkg.sv]
// Shared definitions for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

  // Number of quaternion parts carried through the divider lanes
  localparam int unsigned NUM_PARTS = 4;

  // Field width of every matrix element and quaternion part
  localparam int unsigned ELEM_W = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Limits of the 16-bit output before clamping to the fixed-point one
  localparam int OUT_MAX = 32767;

endpackage

[src/rmq_front.sv]
// Front stages: branch choice, radicand and parts, squares, sum of squares.
// Depends on rmq_pkg.
module rmq_front #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned MW        = 18,
  parameter int unsigned SQW       = 38
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rmq_pkg::elem_t            xx_i,
  input  rmq_pkg::elem_t            xy_i,
  input  rmq_pkg::elem_t            xz_i,
  input  rmq_pkg::elem_t            yx_i,
  input  rmq_pkg::elem_t            yy_i,
  input  rmq_pkg::elem_t            yz_i,
  input  rmq_pkg::elem_t            zx_i,
  input  rmq_pkg::elem_t            zy_i,
  input  rmq_pkg::elem_t            zz_i,
  output logic                      valid_o,
  output logic                      bad_o,
  output logic [3:0]                sign_o,
  output logic [3:0][MW-1:0]        mag_o,
  output logic [SQW-1:0]            sumsq_o
);

  localparam int unsigned CW = MW + 1;
  localparam logic signed [CW-1:0] One = CW'(64'd1 << FRAC_BITS);

  logic signed [CW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, trace;
  logic signed [CW-1:0] rad;
  logic signed [3:0][CW-1:0] c;

  assign xx = CW'(xx_i);
  assign xy = CW'(xy_i);
  assign xz = CW'(xz_i);
  assign yx = CW'(yx_i);
  assign yy = CW'(yy_i);
  assign yz = CW'(yz_i);
  assign zx = CW'(zx_i);
  assign zy = CW'(zy_i);
  assign zz = CW'(zz_i);
  assign trace = xx + yy + zz;

  always_comb begin
    if (trace > 0) begin
      rad  = One + trace;
      c[0] = rad;     c[1] = zy - yz; c[2] = xz - zx; c[3] = yx - xy;
    end else if (xx > yy && xx > zz) begin
      rad  = One + xx - yy - zz;
      c[0] = zy - yz; c[1] = rad;     c[2] = xy + yx; c[3] = xz + zx;
    end else if (yy > zz) begin
      rad  = One + yy - xx - zz;
      c[0] = xz - zx; c[1] = xy + yx; c[2] = rad;     c[3] = yz + zy;
    end else begin
      rad  = One + zz - xx - yy;
      c[0] = yx - xy; c[1] = xz + zx; c[2] = yz + zy; c[3] = rad;
    end
  end

  // stage 1: parts and radicand
  logic                      v1_q, v2_q, v3_q;
  logic signed [3:0][CW-1:0] c1_q;
  logic                      bad1_q, bad2_q, bad3_q;
  logic [3:0]                sg2_q, sg3_q;
  logic [3:0][MW-1:0]        m2_q, m3_q;
  logic [3:0][2*MW-1:0]      sq2_q;
  logic [SQW-1:0]            sum3_q;
  logic [3:0][MW-1:0]        mag1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag1[i] = c1_q[i][CW-1] ? MW'(-c1_q[i]) : MW'(c1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= c;
      bad1_q <= (rad <= 0);
      bad2_q <= bad1_q;
      for (int i = 0; i < 4; i++) begin
        sg2_q[i] <= c1_q[i][CW-1];
        m2_q[i]  <= mag1[i];
        sq2_q[i] <= (2*MW)'(mag1[i]) * (2*MW)'(mag1[i]);
      end
      bad3_q <= bad2_q;
      sg3_q  <= sg2_q;
      m3_q   <= m2_q;
      sum3_q <= SQW'(sq2_q[0]) + SQW'(sq2_q[1]) + SQW'(sq2_q[2]) + SQW'(sq2_q[3]);
    end
  end

  assign valid_o = v3_q;
  assign bad_o   = bad3_q;
  assign sign_o  = sg3_q;
  assign mag_o   = m3_q;
  assign sumsq_o = sum3_q;

endmodule

[src/rmq_sqrt_cell.sv]
// One bit of the integer square root, restoring form.
// Depends on nothing.
module rmq_sqrt_cell #(
  parameter int unsigned SQW    = 38,
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQW-1:0]    v_i,
  input  logic [SQW-1:0]    r_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SQW-1:0]    v_o,
  output logic [SQW-1:0]    r_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [SQW-1:0] B = SQW'(1) << (2 * BIT);

  logic [SQW-1:0] t, v_d, r_d;

  assign t = r_i + B;

  always_comb begin
    if (v_i >= t) begin
      v_d = v_i - t;
      r_d = (r_i >> 1) + B;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  logic              valid_q;
  logic [SQW-1:0]    v_q, r_q;
  logic [SIDE_W-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_d;
      r_q    <= r_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign v_o     = v_q;
  assign r_o     = r_q;
  assign side_o  = side_q;

endmodule

[src/rmq_div_cell.sv]
// One quotient bit of four restoring dividers sharing a divisor.
// Depends on rmq_pkg.
module rmq_div_cell #(
  parameter int unsigned DW     = 36,
  parameter int unsigned NW     = 19,
  parameter int unsigned QB     = 15,
  parameter int unsigned SH     = 0,
  parameter int unsigned SIDE_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NW-1:0]        norm_i,
  input  logic [3:0][DW-1:0]   rem_i,
  input  logic [3:0][QB-1:0]   quo_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [NW-1:0]        norm_o,
  output logic [3:0][DW-1:0]   rem_o,
  output logic [3:0][QB-1:0]   quo_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic [DW-1:0]         dsh;
  logic [3:0][DW-1:0]    rem_d;
  logic [3:0][QB-1:0]    quo_d;

  assign dsh = DW'(norm_i) << SH;

  always_comb begin
    for (int i = 0; i < rmq_pkg::NUM_PARTS; i++) begin
      if (rem_i[i] >= dsh) begin
        rem_d[i] = rem_i[i] - dsh;
        quo_d[i] = quo_i[i] | (QB'(1) << SH);
      end else begin
        rem_d[i] = rem_i[i];
        quo_d[i] = quo_i[i];
      end
    end
  end

  logic                valid_q;
  logic [NW-1:0]       norm_q;
  logic [3:0][DW-1:0]  rem_q;
  logic [3:0][QB-1:0]  quo_q;
  logic [SIDE_W-1:0]   side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= norm_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

[src/rotation_matrix_to_quaternion_unit.sv]
// Top level: rotation matrix to conjugated unit quaternion (Shepperd).
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell.
//
// Input channel: in_valid_i/in_ready_o carry one word of nine Q1.14 matrix
// elements (three axis vectors). Output channel: out_valid_o/out_ready_i carry
// one word of four quaternion parts plus bad_input_o.
// One result word per input word, in order.
// Pipeline: 3 front stages, MW+1 square-root cells, FRAC_BITS+1 divider cells
// and an output register.
// Throughput: one word per cycle unless the receiver stalls; every cell of the
// root and divider chains hands its word to the next cell each enabled cycle.
// When the receiver stalls with a word held in the output register, the whole
// chain freezes and in_ready_o drops; it rises again once that word is taken.
// Reset clears all valid flags; no words are in flight afterwards.
// A non-positive radicand or zero norm gives the identity and bad_input_o.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rmq_pkg::elem_t xaxis_x_i,
  input  rmq_pkg::elem_t xaxis_y_i,
  input  rmq_pkg::elem_t xaxis_z_i,
  input  rmq_pkg::elem_t yaxis_x_i,
  input  rmq_pkg::elem_t yaxis_y_i,
  input  rmq_pkg::elem_t yaxis_z_i,
  input  rmq_pkg::elem_t zaxis_x_i,
  input  rmq_pkg::elem_t zaxis_y_i,
  input  rmq_pkg::elem_t zaxis_z_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rmq_pkg::elem_t quat_w_o,
  output rmq_pkg::elem_t quat_x_o,
  output rmq_pkg::elem_t quat_y_o,
  output rmq_pkg::elem_t quat_z_o,
  output logic           bad_input_o
);

  localparam int unsigned MW     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int unsigned NSQ    = MW + 1;
  localparam int unsigned SQW    = 2 * NSQ;
  localparam int unsigned QB     = FRAC_BITS + 1;
  localparam int unsigned DW     = MW + FRAC_BITS + 3;
  localparam int unsigned SSIDE  = 1 + 4 + 4 * MW;
  localparam int unsigned DSIDE  = 1 + 4;
  localparam int unsigned CLW    = QB + 2;
  localparam int unsigned OW     = rmq_pkg::ELEM_W;
  localparam longint      OneL   = longint'(1) << FRAC_BITS;
  localparam logic signed [CLW-1:0] Hi =
    CLW'((OneL < rmq_pkg::OUT_MAX) ? OneL : longint'(rmq_pkg::OUT_MAX));
  localparam logic signed [CLW-1:0] Lo = -Hi - CLW'(OneL > rmq_pkg::OUT_MAX);

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // front
  logic               f_valid, f_bad;
  logic [3:0]         f_sign;
  logic [3:0][MW-1:0] f_mag;
  logic [SQW-1:0]     f_sum;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .MW(MW), .SQW(SQW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .xx_i(xaxis_x_i), .xy_i(xaxis_y_i), .xz_i(xaxis_z_i),
    .yx_i(yaxis_x_i), .yy_i(yaxis_y_i), .yz_i(yaxis_z_i),
    .zx_i(zaxis_x_i), .zy_i(zaxis_y_i), .zz_i(zaxis_z_i),
    .valid_o(f_valid), .bad_o(f_bad), .sign_o(f_sign), .mag_o(f_mag),
    .sumsq_o(f_sum)
  );

  // square root chain
  logic [NSQ:0]            s_valid;
  logic [NSQ:0][SQW-1:0]   s_v, s_r;
  logic [NSQ:0][SSIDE-1:0] s_side;

  assign s_valid[0] = f_valid;
  assign s_v[0]     = f_sum;
  assign s_r[0]     = '0;
  assign s_side[0]  = {f_bad, f_sign, f_mag};

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    rmq_sqrt_cell #(.SQW(SQW), .BIT(NSQ - 1 - k), .SIDE_W(SSIDE)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(s_valid[k]), .v_i(s_v[k]), .r_i(s_r[k]), .side_i(s_side[k]),
      .valid_o(s_valid[k+1]), .v_o(s_v[k+1]), .r_o(s_r[k+1]),
      .side_o(s_side[k+1])
    );
  end

  // divider chain, numerator is mag * one + norm / 2
  logic [NSQ-1:0]     norm0;
  logic [3:0][MW-1:0] smag;
  logic [3:0]         ssign;
  logic               sbad;

  assign norm0 = s_r[NSQ][NSQ-1:0];
  assign {sbad, ssign, smag} = s_side[NSQ];

  logic [QB:0]                d_valid;
  logic [QB:0][NSQ-1:0]       d_norm;
  logic [QB:0][3:0][DW-1:0]   d_rem;
  logic [QB:0][3:0][QB-1:0]   d_quo;
  logic [QB:0][DSIDE-1:0]     d_side;

  assign d_valid[0] = s_valid[NSQ];
  assign d_norm[0]  = norm0;
  assign d_quo[0]   = '0;
  assign d_side[0]  = {sbad || (norm0 == '0), ssign};

  for (genvar i = 0; i < rmq_pkg::NUM_PARTS; i++) begin : g_num
    assign d_rem[0][i] = (DW'(smag[i]) << FRAC_BITS) + DW'(norm0 >> 1);
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    rmq_div_cell #(
      .DW(DW), .NW(NSQ), .QB(QB), .SH(QB - 1 - k), .SIDE_W(DSIDE)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d_valid[k]), .norm_i(d_norm[k]), .rem_i(d_rem[k]),
      .quo_i(d_quo[k]), .side_i(d_side[k]),
      .valid_o(d_valid[k+1]), .norm_o(d_norm[k+1]), .rem_o(d_rem[k+1]),
      .quo_o(d_quo[k+1]), .side_o(d_side[k+1])
    );
  end

  // sign, clamp and conjugate
  logic                       dbad;
  logic [3:0]                 dsign;
  logic signed [3:0][CLW-1:0] part, clp;
  logic [3:0][OW-1:0]         res;

  assign {dbad, dsign} = d_side[QB];

  // elements of a packed array read as unsigned, so compare through $signed
  always_comb begin
    for (int i = 0; i < rmq_pkg::NUM_PARTS; i++) begin
      part[i] = dsign[i] ? -CLW'(d_quo[QB][i]) : CLW'(d_quo[QB][i]);
      if ($signed(part[i]) > Hi) begin
        clp[i] = Hi;
      end else if ($signed(part[i]) < Lo) begin
        clp[i] = Lo;
      end else begin
        clp[i] = part[i];
      end
    end
    res[0] = dbad ? OW'(Hi) : OW'(clp[0]);
    for (int i = 1; i < rmq_pkg::NUM_PARTS; i++) begin
      res[i] = dbad ? '0 : OW'(-(CLW + 1)'(clp[i]));
    end
  end

  logic [3:0][OW-1:0] res_q;
  logic               bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res;
      bad_q <= dbad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_w_o    = res_q[0];
  assign quat_x_o    = res_q[1];
  assign quat_y_o    = res_q[2];
  assign quat_z_o    = res_q[3];
  assign bad_input_o = bad_q;

  a_bad_identity_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |-> (quat_w_o == OW'(Hi)))
    else $error("bad word without unit scalar part");

  a_bad_identity_v : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |->
      (quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0))
    else $error("bad word with non-zero vector part");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> ($stable(d_valid) && $stable(s_valid)))
    else $error("chain moved while output stalled");

endmodule

[tb/tb_rotation_matrix_to_quaternion_unit.sv]
// Testbench for rotation_matrix_to_quaternion_unit: directed table, then random
// matrices, checked against an in-bench fixed-point predictor. Depends on rmq_pkg.
module tb_rotation_matrix_to_quaternion_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef rmq_pkg::elem_t elem_t;

  localparam int unsigned FRAC_BITS = 14;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int LATENCY = 40;
  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 600;

  typedef struct packed {
    elem_t xx, xy, xz, yx, yy, yz, zx, zy, zz;
  } matrix_t;

  typedef struct packed {
    elem_t w, x, y, z;
    logic  bad;
  } quat_t;

  typedef struct {
    matrix_t m;
    bit      typed;
    quat_t   q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  matrix_t mat = '0;
  logic in_ready_o, out_valid_o, bad_input_o;
  elem_t quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_t quat_queue[$];
  int mismatches = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 62;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .xaxis_x_i(mat.xx), .xaxis_y_i(mat.xy), .xaxis_z_i(mat.xz),
    .yaxis_x_i(mat.yx), .yaxis_y_i(mat.yy), .yaxis_z_i(mat.yz),
    .zaxis_x_i(mat.zx), .zaxis_y_i(mat.zy), .zaxis_z_i(mat.zz),
    .out_valid_o, .out_ready_i,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o, .bad_input_o
  );

  function automatic longint clamp_part(longint v);
    longint hi, lo;
    hi = (ONE < 32767) ? ONE : 32767;
    lo = (-ONE > -32768) ? -ONE : -32768;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_to_unit(longint c, longint unsigned norm);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (mag * longint'(ONE) + norm / 2) / norm;
    return clamp_part((c < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t shepperd_quat(matrix_t m);
    longint xx, xy, xz, yx, yy, yz, zx, zy, zz, trace, rad;
    longint c[4];
    longint unsigned sumsq, norm, mg;
    quat_t q;
    xx = m.xx; xy = m.xy; xz = m.xz;
    yx = m.yx; yy = m.yy; yz = m.yz;
    zx = m.zx; zy = m.zy; zz = m.zz;
    trace = xx + yy + zz;
    if (trace > 0) begin
      rad = ONE + trace;
      c = '{rad, zy - yz, xz - zx, yx - xy};
    end else if (xx > yy && xx > zz) begin
      rad = ONE + xx - yy - zz;
      c = '{zy - yz, rad, xy + yx, xz + zx};
    end else if (yy > zz) begin
      rad = ONE + yy - xx - zz;
      c = '{xz - zx, xy + yx, rad, yz + zy};
    end else begin
      rad = ONE + zz - xx - yy;
      c = '{yx - xy, xz + zx, yz + zy, rad};
    end
    sumsq = 0;
    norm = 0;
    if (rad > 0) begin
      foreach (c[i]) begin
        mg = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
        sumsq += mg * mg;
      end
      norm = int_sqrt(sumsq);
    end
    if (rad <= 0 || norm == 0) begin
      q.w = elem_t'(clamp_part(ONE));
      q.x = '0; q.y = '0; q.z = '0;
      q.bad = 1'b1;
    end else begin
      q.w = elem_t'(scale_to_unit(c[0], norm));
      q.x = elem_t'(-scale_to_unit(c[1], norm));
      q.y = elem_t'(-scale_to_unit(c[2], norm));
      q.z = elem_t'(-scale_to_unit(c[3], norm));
      q.bad = 1'b0;
    end
    return q;
  endfunction

  function automatic matrix_t mk(int a, int b, int c, int d, int e, int f,
                                 int g, int h, int k);
    mk = '{elem_t'(a), elem_t'(b), elem_t'(c), elem_t'(d), elem_t'(e),
           elem_t'(f), elem_t'(g), elem_t'(h), elem_t'(k)};
  endfunction

  localparam int P = 16384;
  localparam int N = -16384;
  localparam quat_t IDENT = '{elem_t'(16384), '0, '0, '0, 1'b0};

  row_t directed[$];

  initial begin
    // identity and half-turns: one per Shepperd branch
    directed.push_back('{mk(P, 0, 0, 0, P, 0, 0, 0, P), 1'b1, IDENT});
    directed.push_back('{mk(P, 0, 0, 0, N, 0, 0, 0, N), 1'b1,
                         '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0}});
    directed.push_back('{mk(N, 0, 0, 0, P, 0, 0, 0, N), 1'b1,
                         '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}});
    directed.push_back('{mk(N, 0, 0, 0, N, 0, 0, 0, P), 1'b1,
                         '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}});
    // zero matrix: z path, radicand one
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}});
    // extreme diagonals: the radicand stays positive on each path they take
    directed.push_back('{mk(P, 0, 0, 0, P, 0, 0, 0, -32768), 1'b1,
                         '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}});
    directed.push_back('{mk(32767, 0, 0, 0, 32767, 0, 0, 0, -32768), 1'b1, IDENT});
    directed.push_back('{mk(P, 0, 0, 0, 0, 0, 0, 0, N), 1'b1,
                         '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0}});
    // ties between diagonals fall through to later paths
    directed.push_back('{mk(-100, 5, 6, 7, -100, 8, 9, 10, -300), 1'b0, '0});
    directed.push_back('{mk(-100, 5, 6, 7, -300, 8, 9, 10, -100), 1'b0, '0});
    directed.push_back('{mk(-200, 5, 6, 7, -100, 8, 9, 10, -100), 1'b0, '0});
    directed.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768), 1'b0, '0});
    directed.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767), 1'b0, '0});
    directed.push_back('{mk(32767, -32768, 32767, -32768, 32767, -32768,
                            32767, -32768, 32767), 1'b0, '0});
    directed.push_back('{mk(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0),
                         1'b0, '0});
    directed.push_back('{mk(0, N, 0, P, 0, 0, 0, 0, P), 1'b0, '0});
    directed.push_back('{mk(1, -1, 1, -1, 1, -1, 1, -1, 1), 1'b0, '0});
  end

  // sampled before the edge's nonblocking updates: a word moves on each pair
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && in_valid_i && in_ready_o) quiet_cycles <= 0;
    else if (rst_ni && out_valid_o && out_ready_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{quat_w_o, quat_x_o, quat_y_o, quat_z_o, bad_input_o};
      if (quat_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = quat_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver
  int hold_count = 0;
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(matrix_t m, quat_t q);
    quat_queue.push_back(q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mat <= m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(16)) - 16'sd8;
      2: return $urandom_range(1) ? elem_t'(16384) : elem_t'(-16384);
      default: return elem_t'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int d;
    m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // bias towards ties between diagonal elements so every branch is well exercised
    d = $urandom_range(3);
    if (d == 1) begin m.yy = -m.xx; m.zz = -m.xx; end
    if (d == 2) begin m.xx = m.yy; end
    return m;
  endfunction

  initial begin
    matrix_t m;
    quat_t q;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      q = shepperd_quat(directed[i].m);
      send_word(directed[i].m, directed[i].typed ? directed[i].q : q);
    end
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 62; recv_idle_pct = 14; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        if (phase == 2 && i == 20) begin
          hold_off = 1'b1;
          fork
            begin
              hold_count = 0;
              while (hold_count < 150) begin @(posedge clk_i); hold_count++; end
              hold_off = 1'b0;
            end
          join_none
        end
        m = rand_matrix();
        send_word(m, shepperd_quat(m));
      end
      drain();  // sender pauses until everything is back
    end
    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0 && !timed_out) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG);
    timed_out = 1'b1;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
